FILE: sv/tia_pkg.sv
// shared types and constants for the triangle inequality average block
package tia_pkg;

  localparam int MaxOrbit    = 1024;
  localparam int MaxAverages = 64;
  localparam int FracBits    = 24;

  typedef struct packed {
    logic [31:0] radius;
    logic [31:0] lower_bound;
    logic [31:0] upper_bound;
    logic        last_element;
  } in_item_t;

  typedef struct packed {
    logic [24:0] average;
    logic [5:0]  average_index;
    logic [1:0]  status;
    logic        last_result;
  } out_item_t;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusShort    = 2'd1;
  localparam logic [1:0] StatusBadDivis = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDIV,
    ST_STORE,
    ST_CHECK,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_SUB_RD,
    ST_SUB_ACC,
    ST_ADIV,
    ST_EMIT,
    ST_SHORT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_item;
    logic start_rdiv;
    logic store_ratio;
    logic clear_counts;
    logic sum_clear;
    logic sum_rd;
    logic sum_acc;
    logic sub_rd;
    logic sub_acc;
    logic start_adiv;
    logic load_out;
    logic load_short;
    logic next_avg;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_done;
    logic last;
    logic is_short;
    logic sum_end;
    logic div_bad;
    logic avg_end;
  } sts_t;

endpackage

FILE: sv/tia_ram.sv
// generic single port write, single port registered read memory
module tia_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/tia_div.sv
// radix-2 restoring divider, one quotient bit per cycle
module tia_div #(
  parameter int NumW = 56,
  parameter int DenW = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic [NumW-1:0] quo,
  output logic            done
);
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] q;
  logic [DenW:0]   rem;
  logic [DenW-1:0] d;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [DenW:0]   trial;
  logic [DenW:0]   shifted;

  always_comb begin
    shifted = {rem[DenW-1:0], q[NumW-1]};
    trial   = shifted - {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(NumW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      d   <= den;
      rem <= '0;
    end else if (busy) begin
      if (!trial[DenW]) begin
        rem <= trial;
        q   <= {q[NumW-2:0], 1'b1};
      end else begin
        rem <= shifted;
        q   <= {q[NumW-2:0], 1'b0};
      end
    end
  end

  assign quo = q;
endmodule

FILE: sv/tia_datapath.sv
// datapath: ratio division, ratio store, running sum and average division
module tia_datapath
  import tia_pkg::*;
#(
  parameter int MAX_ORBIT    = MaxOrbit,
  parameter int MAX_AVERAGES = MaxAverages,
  parameter int FRAC_BITS    = FracBits
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  output sts_t      sts,
  input  in_item_t  item,
  input  logic [6:0] average_count,
  output out_item_t result
);
  localparam int AddrW = $clog2(MAX_ORBIT);
  localparam int CntW  = $clog2(MAX_ORBIT + 1);
  localparam int NumW  = 32 + FRAC_BITS;
  localparam int SumW  = FRAC_BITS + CntW;
  localparam int AvgW  = $clog2(MAX_AVERAGES + 1);
  localparam logic [FRAC_BITS:0] One = {1'b1, {FRAC_BITS{1'b0}}};

  logic [31:0]          num_abs, den_abs;
  logic                 num_neg, den_neg;
  logic                 ratio_zero, zero_w, last;
  logic [CntW-1:0]      n, zeros, ptr;
  logic [SumW-1:0]      sum;
  logic [AvgW-1:0]      size, i;
  logic [FRAC_BITS-1:0] rd_data, ratio;
  logic [AddrW-1:0]     raddr;
  logic                 div_start, div_done;
  logic [NumW-1:0]      div_num, quo;
  logic [31:0]          div_den;
  logic signed [CntW+1:0] divisor;
  logic [AvgW-1:0]      size_c;

  always_comb begin
    if (average_count == 7'd0) size_c = AvgW'(1);
    else if ({1'b0, average_count} > 8'(MAX_AVERAGES)) size_c = AvgW'(MAX_AVERAGES);
    else size_c = AvgW'(average_count);
  end

  // absolute differences straight from the offered item
  always_comb begin
    num_neg = item.radius < item.lower_bound;
    den_neg = item.upper_bound < item.lower_bound;
    num_abs = num_neg ? item.lower_bound - item.radius : item.radius - item.lower_bound;
    den_abs = den_neg ? item.lower_bound - item.upper_bound
                      : item.upper_bound - item.lower_bound;
  end

  // item load: the zero-ratio case and flags
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      ratio_zero <= (item.radius == item.lower_bound) ||
                    (item.upper_bound == item.lower_bound) || (num_neg != den_neg);
      zero_w     <= item.upper_bound == item.lower_bound;
      last       <= item.last_element;
    end
  end

  assign divisor = $signed({2'b00, n}) - $signed({{(CntW+2-AvgW){1'b0}}, i})
                 - $signed({2'b00, zeros});

  always_comb begin
    div_start = cmd.start_rdiv | cmd.start_adiv;
    if (cmd.start_adiv) begin
      div_num = NumW'(sum);
      div_den = 32'(divisor[CntW-1:0]);
    end else begin
      div_num = {num_abs, {FRAC_BITS{1'b0}}};
      div_den = den_abs;
    end
  end

  tia_div #(.NumW(NumW), .DenW(32)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .quo(quo), .done(div_done)
  );

  always_comb begin
    if (ratio_zero) ratio = '0;
    else if (quo > NumW'({FRAC_BITS{1'b1}})) ratio = '1;
    else ratio = quo[FRAC_BITS-1:0];
  end

  always_comb begin
    if (cmd.sub_rd) raddr = AddrW'(n - CntW'(i));
    else raddr = ptr[AddrW-1:0];
  end

  tia_ram #(.Width(FRAC_BITS), .Depth(MAX_ORBIT)) u_ram (
    .clk(clk), .we(cmd.store_ratio && n < CntW'(MAX_ORBIT)),
    .waddr(n[AddrW-1:0]), .wdata(ratio), .raddr(raddr), .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      n        <= '0;
      zeros    <= '0;
    end else begin
      if (cmd.clear_counts) begin
        n <= '0;
        zeros <= '0;
      end else if (cmd.store_ratio && n < CntW'(MAX_ORBIT)) begin
        n <= n + 1'b1;
        if (zero_w) zeros <= zeros + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_clear) begin
      sum  <= '0;
      ptr  <= '0;
      i    <= '0;
      size <= size_c;
    end
    if (cmd.sum_rd) ptr <= ptr + 1'b1;
    if (cmd.sum_acc || cmd.sub_acc) begin
      if (cmd.sum_acc) sum <= sum + SumW'(rd_data);
      else sum <= sum - SumW'(rd_data);
    end
    if (cmd.next_avg) i <= i + 1'b1;
    if (cmd.load_out) begin
      result.average_index <= 6'(i);
      result.last_result   <= (i + 1'b1) == size;
      if (divisor <= 0) begin
        result.average <= '0;
        result.status  <= StatusBadDivis;
      end else begin
        result.average <= (quo > NumW'(One)) ? 25'(One) : 25'(quo);
        result.status  <= StatusOk;
      end
    end else if (cmd.load_short) begin
      result.average       <= '0;
      result.average_index <= '0;
      result.status        <= StatusShort;
      result.last_result   <= 1'b1;
    end
  end

  always_comb begin
    sts.div_done = div_done;
    sts.last     = last;
    sts.is_short = n < CntW'(size_c);
    sts.sum_end  = ptr == n;
    sts.div_bad  = divisor <= 0;
    sts.avg_end  = (i + 1'b1) == size;
  end
endmodule

FILE: sv/tia_ctrl.sv
// controller state machine
module tia_ctrl
  import tia_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic out_busy,
  input  sts_t sts,
  output cmd_t cmd,
  output logic in_ready,
  output logic out_load
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_fire) state_next = ST_RDIV;
      ST_RDIV:    if (sts.div_done) state_next = ST_STORE;
      ST_STORE:   state_next = sts.last ? ST_CHECK : ST_IDLE;
      ST_CHECK:   state_next = sts.is_short ? ST_SHORT : ST_SUM_RD;
      ST_SUM_RD:  state_next = sts.sum_end ? ST_ADIV : ST_SUM_ACC;
      ST_SUM_ACC: state_next = ST_SUM_RD;
      ST_ADIV:    if (sts.div_done) state_next = ST_EMIT;
      ST_EMIT:    if (!out_busy) state_next = sts.avg_end ? ST_IDLE : ST_SUB_RD;
      ST_SUB_RD:  state_next = ST_SUB_ACC;
      // the read pointer already sits at the end, so this starts the next division
      ST_SUB_ACC: state_next = ST_SUM_RD;
      ST_SHORT:   if (!out_busy) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.load_item  = in_fire;
        cmd.start_rdiv = in_fire;
      end
      ST_STORE: cmd.store_ratio = 1'b1;
      ST_CHECK: cmd.sum_clear = 1'b1;
      ST_SUM_RD: begin
        cmd.sum_rd     = !sts.sum_end;
        cmd.start_adiv = sts.sum_end;
      end
      ST_SUM_ACC: cmd.sum_acc = 1'b1;
      ST_EMIT: if (!out_busy) begin
        cmd.load_out = 1'b1;
        out_load     = 1'b1;
        cmd.next_avg = !sts.avg_end;
        cmd.clear_counts = sts.avg_end;
      end
      ST_SUB_RD: cmd.sub_rd = 1'b1;
      ST_SUB_ACC: begin
        cmd.sub_acc    = 1'b1;
      end
      ST_ADIV: cmd.start_adiv = 1'b0;
      ST_SHORT: if (!out_busy) begin
        cmd.load_short   = 1'b1;
        out_load         = 1'b1;
        cmd.clear_counts = 1'b1;
      end
      default: ;
    endcase
  end
endmodule

FILE: sv/triangle_inequality_average.sv
// top level of the triangle inequality average coloring block
// Each orbit element item has its ratio computed by one shared radix-2 divider (one
// quotient bit per cycle over a 56-bit dividend) and written to the ratio memory. The
// last element of an orbit then sums all stored ratios and produces average_count
// averages (zero counts as one, at most MAX_AVERAGES), each a further divider pass,
// those after the first once one ratio is subtracted. Results leave through an output
// register, so a waiting result only stalls the next result, not item intake before it.
module triangle_inequality_average
  import tia_pkg::*;
#(
  parameter int MAX_ORBIT    = MaxOrbit,
  parameter int MAX_AVERAGES = MaxAverages,
  parameter int FRAC_BITS    = FracBits
) (
  input  logic      clk,
  input  logic      rst,
  // configuration
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  // input items
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  // result items
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);
  logic [6:0] average_count;
  cmd_t       cmd;
  sts_t       sts;
  logic       in_fire, out_fire, out_load;
  out_item_t  result;

  // configuration register, reset to one average
  always_ff @(posedge clk) begin
    if (rst) average_count <= 7'd1;
    else if (cfg_we) average_count <= cfg_wdata;
  end

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  tia_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_busy(out_valid && !out_ready),
    .sts(sts), .cmd(cmd), .in_ready(in_ready),
    .out_load(out_load)
  );

  tia_datapath #(
    .MAX_ORBIT(MAX_ORBIT), .MAX_AVERAGES(MAX_AVERAGES), .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .item(in_item),
    .average_count(average_count), .result(result)
  );

  // output register: result is written into the datapath register the cycle out_load
  // is high, and valid rises in the cycle after that write, through load_d
  logic load_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      load_d    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      load_d <= out_load;
      if (load_d) out_valid <= 1'b1;
      else if (out_fire) out_valid <= 1'b0;
    end
  end
  assign out_item = result;

  // a held result must not change
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_item))
    else $error("result changed while stalled");

  // no new result load while one is pending
  assert property (@(posedge clk) disable iff (rst)
    load_d |-> !out_valid || out_fire)
    else $error("result overwritten");

  // items are never taken while a result load is in flight
  assert property (@(posedge clk) disable iff (rst)
    in_fire |-> !out_load)
    else $error("item accepted during result load");
endmodule
